// ----- rtl/cfpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant pool parser package
// Shared types, record codes, tag codes and the payload length table.
// ----------------------------------------------------------------------------
package cfpp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_MINOR   = 3'd1,
        PH_MAJOR   = 3'd2,
        PH_COUNT   = 3'd3,
        PH_TAG     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHARS   = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    localparam logic [3:0] KIND_MAGIC    = 4'd0;
    localparam logic [3:0] KIND_VERSION  = 4'd1;
    localparam logic [3:0] KIND_COUNT    = 4'd2;
    localparam logic [3:0] KIND_UTF8_LEN = 4'd3;
    localparam logic [3:0] KIND_UTF8_CHR = 4'd4;
    localparam logic [3:0] KIND_CLASS    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_MEMBER   = 4'd7;
    localparam logic [3:0] KIND_NAMETYPE = 4'd8;
    localparam logic [3:0] KIND_SKIPPED  = 4'd9;
    localparam logic [3:0] KIND_BAD_TAG  = 4'd10;

    localparam logic [7:0] TAG_UTF8      = 8'd1;
    localparam logic [7:0] TAG_INTEGER   = 8'd3;
    localparam logic [7:0] TAG_FLOAT     = 8'd4;
    localparam logic [7:0] TAG_LONG      = 8'd5;
    localparam logic [7:0] TAG_DOUBLE    = 8'd6;
    localparam logic [7:0] TAG_CLASS     = 8'd7;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_FIELDREF  = 8'd9;
    localparam logic [7:0] TAG_METHODREF = 8'd10;
    localparam logic [7:0] TAG_NAMETYPE  = 8'd12;
    localparam logic [7:0] TAG_MHANDLE   = 8'd15;
    localparam logic [7:0] TAG_MTYPE     = 8'd16;

    localparam logic [15:0] MAGIC_BYTES = 16'd4;
    localparam logic [15:0] HALF_BYTES  = 16'd2;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] bytes_left;
        logic [31:0] gather_word;
        logic [15:0] held_first_index;
        logic [15:0] pool_total;
        logic [15:0] current_index;
        logic [7:0]  current_tag;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [15:0] entry_index;
        logic [31:0] value_high;
        logic [15:0] value_low;
        logic [7:0]  constant_tag;
        logic        pool_finished;
    } record_t;

    function automatic logic [3:0] payload_length(input logic [7:0] tag);
        logic [3:0] len;
        unique case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_MTYPE:                   len = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_NAMETYPE: len = 4'd4;
            TAG_LONG, TAG_DOUBLE:                                          len = 4'd8;
            TAG_MHANDLE:                                                   len = 4'd3;
            default:                                                       len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/cfpp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant pool parser step
// Next parser state and the record, if any, for one stream byte.
// ----------------------------------------------------------------------------
module cfpp_step
    import cfpp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   data_byte,
    input  logic         wide_takes_two_slots,
    output parse_state_t nxt,
    output logic         rec_valid,
    output record_t      rec
);

    logic [15:0] dec;
    logic [31:0] shifted;
    logic        step_two;
    logic [16:0] next_index;
    logic        ends_pool;
    logic [3:0]  tag_len;

    assign dec      = cur.bytes_left - 16'd1;
    assign shifted  = {cur.gather_word[23:0], data_byte};
    assign tag_len  = payload_length(data_byte);
    assign step_two = (cur.phase != PH_TAG) && wide_takes_two_slots &&
                      ((cur.current_tag == TAG_LONG) || (cur.current_tag == TAG_DOUBLE));
    assign next_index = {1'b0, cur.current_index} + (step_two ? 17'd2 : 17'd1);
    assign ends_pool  = next_index >= {1'b0, cur.pool_total};

    always_comb
    begin
        nxt       = cur;
        rec_valid = 1'b0;
        rec       = '0;
        rec.entry_index  = cur.current_index;
        rec.constant_tag = cur.current_tag;

        unique case (cur.phase)
            PH_TAG:
            begin
                nxt.current_tag = data_byte;
                if (tag_len == 4'd0)
                begin
                    rec_valid         = 1'b1;
                    rec.record_kind   = KIND_BAD_TAG;
                    rec.constant_tag  = data_byte;
                    rec.pool_finished = ends_pool;
                end
                else
                begin
                    nxt.bytes_left  = {12'd0, tag_len};
                    nxt.gather_word = '0;
                    nxt.phase       = PH_PAYLOAD;
                end
            end
            PH_CHARS:
            begin
                nxt.bytes_left    = dec;
                rec_valid         = 1'b1;
                rec.record_kind   = KIND_UTF8_CHR;
                rec.value_high    = {24'd0, data_byte};
                rec.pool_finished = (dec == 16'd0) && ends_pool;
            end
            PH_DONE:
            begin
                nxt = cur;
            end
            PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT, PH_PAYLOAD:
            begin
                nxt.gather_word = shifted;
                nxt.bytes_left  = dec;
                if (dec == 16'd0)
                begin
                    unique case (cur.phase)
                        PH_MAGIC:
                        begin
                            nxt.phase        = PH_MINOR;
                            nxt.bytes_left   = HALF_BYTES;
                            rec_valid        = 1'b1;
                            rec.record_kind  = KIND_MAGIC;
                            rec.entry_index  = '0;
                            rec.constant_tag = '0;
                            rec.value_high   = shifted;
                        end
                        PH_MINOR:
                        begin
                            nxt.held_first_index = shifted[15:0];
                            nxt.phase            = PH_MAJOR;
                            nxt.bytes_left       = HALF_BYTES;
                            nxt.gather_word      = '0;
                        end
                        PH_MAJOR:
                        begin
                            nxt.phase        = PH_COUNT;
                            nxt.bytes_left   = HALF_BYTES;
                            rec_valid        = 1'b1;
                            rec.record_kind  = KIND_VERSION;
                            rec.entry_index  = '0;
                            rec.constant_tag = '0;
                            rec.value_high   = {16'd0, shifted[15:0]};
                            rec.value_low    = cur.held_first_index;
                        end
                        PH_COUNT:
                        begin
                            nxt.pool_total    = shifted[15:0];
                            nxt.current_index = 16'd1;
                            nxt.phase = (shifted[15:0] <= 16'd1) ? PH_DONE : PH_TAG;
                            rec_valid         = 1'b1;
                            rec.record_kind   = KIND_COUNT;
                            rec.entry_index   = '0;
                            rec.constant_tag  = '0;
                            rec.value_high    = {16'd0, shifted[15:0]};
                            rec.pool_finished = (shifted[15:0] <= 16'd1);
                        end
                        default:
                        begin
                            rec_valid         = 1'b1;
                            rec.pool_finished = ends_pool;
                            unique case (cur.current_tag)
                                TAG_UTF8:
                                begin
                                    rec.record_kind = KIND_UTF8_LEN;
                                    rec.value_high  = {16'd0, shifted[15:0]};
                                    if (shifted[15:0] != 16'd0)
                                    begin
                                        rec.pool_finished = 1'b0;
                                        nxt.bytes_left    = shifted[15:0];
                                        nxt.phase         = PH_CHARS;
                                    end
                                end
                                TAG_CLASS:
                                begin
                                    rec.record_kind = KIND_CLASS;
                                    rec.value_high  = {16'd0, shifted[15:0]};
                                end
                                TAG_STRING:
                                begin
                                    rec.record_kind = KIND_STRING;
                                    rec.value_high  = {16'd0, shifted[15:0]};
                                end
                                TAG_FIELDREF, TAG_METHODREF:
                                begin
                                    rec.record_kind = KIND_MEMBER;
                                    rec.value_high  = {16'd0, shifted[31:16]};
                                    rec.value_low   = shifted[15:0];
                                end
                                TAG_NAMETYPE:
                                begin
                                    rec.record_kind = KIND_NAMETYPE;
                                    rec.value_high  = {16'd0, shifted[31:16]};
                                    rec.value_low   = shifted[15:0];
                                end
                                default:
                                begin
                                    rec.record_kind = KIND_SKIPPED;
                                end
                            endcase
                        end
                    endcase
                end
            end
        endcase

        // An entry completes on the record for a bad tag, a last character or a
        // finished payload, but not on a UTF8 length that has characters to follow.
        if (rec_valid && (cur.phase == PH_TAG || cur.phase == PH_CHARS ||
                          cur.phase == PH_PAYLOAD) &&
            !(cur.phase == PH_CHARS && dec != 16'd0) &&
            !(cur.phase == PH_PAYLOAD && nxt.phase == PH_CHARS))
        begin
            if (ends_pool)
            begin
                nxt.phase = PH_DONE;
            end
            else
            begin
                nxt.current_index = next_index[15:0];
                nxt.phase         = PH_TAG;
            end
        end
    end

endmodule

// ----- rtl/class_file_constant_pool_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class file constant pool parser
// Walks the header and constant pool of a class file stream, one byte a cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// The slave stream carries one class file byte per transfer. The master
// stream gives one record per header field (minor and major share one), pool
// entry index set, string length, string character, skipped payload or unknown
// tag; m_tuser carries the record kind and m_tlast marks the record that
// completes the last pool entry or the count of an empty pool. Bytes after
// the pool, and bytes that only add to a word being gathered, give no record.
// A byte is held in the input register until it advances, and its record is
// then loaded into the output register, where it waits for the receiver.
// One byte is taken in every cycle while the receiver does not stall.
// When the receiver stalls, the record waits in the output register and
// one more byte is held in the input register before s_tready falls.
// The cfg channel writes the Long/Double two-slot select; it is always
// ready and must be written only while the parser is idle.
// Reset returns the parser to the magic word, clears the valid flags of both
// registers and sets the two-slot select to one.
// ----------------------------------------------------------------------------
module class_file_constant_pool_parser_unit
    import cfpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [3:0]  m_tuser,   // [3:0] record_kind
    output logic [71:0] m_tdata,   // [15:0] entry_index, [47:16] value_high,
                                   // [63:48] value_low, [71:64] constant_tag
    output logic        m_tlast,   // pool_finished
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    record_t      out_rec_reg;
    logic         wide_reg;
    logic         rec_valid;
    record_t      rec;
    logic         advance;

    cfpp_step u_step
    (
        .cur                  (state_reg),
        .data_byte            (in_byte_reg),
        .wide_takes_two_slots (wide_reg),
        .nxt                  (state_next),
        .rec_valid            (rec_valid),
        .rec                  (rec)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wide_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                <= 1'b0;
            state_reg.phase             <= PH_MAGIC;
            state_reg.bytes_left        <= MAGIC_BYTES;
            state_reg.gather_word       <= '0;
            state_reg.held_first_index  <= '0;
            state_reg.pool_total        <= '0;
            state_reg.current_index     <= 16'd1;
            state_reg.current_tag       <= '0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= rec_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rec_reg.record_kind;
    assign m_tdata  = {out_rec_reg.constant_tag, out_rec_reg.value_low,
                       out_rec_reg.value_high, out_rec_reg.entry_index};
    assign m_tlast  = out_rec_reg.pool_finished;

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE |=> state_reg.phase == PH_DONE)
        else $error("parser left the done phase");

    a_index_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_TAG || state_reg.phase == PH_PAYLOAD ||
         state_reg.phase == PH_CHARS) |->
        (state_reg.current_index != 16'd0 &&
         state_reg.current_index < state_reg.pool_total))
        else $error("entry index outside the pool");

    a_chars_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_CHARS |-> state_reg.bytes_left != 16'd0)
        else $error("character phase with no bytes left");

    a_last_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rec_reg.pool_finished) |-> state_reg.phase == PH_DONE)
        else $error("pool end reported while parsing continues");

endmodule
